/* src/bps_pkg.sv */
// Shared types, constants and arithmetic helpers for the beacon PID steering core.
`default_nettype none

package bps_pkg;

  // Reading width; left and right readings use this many bits.
  localparam int READING_BITS = 10;

  // Configuration port.
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 20;

  localparam logic [CFG_IDX_BITS-1:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_INTEG_GAIN  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_DERIV_GAIN  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRONT_MIN   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_REAR_MIN    = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_INTEG_LIMIT = 3'd5;

  localparam logic signed [15:0] PROP_GAIN_RST   = 16'sd256;
  localparam logic [READING_BITS-1:0] MIN_LEVEL_RST = READING_BITS'(50);
  localparam logic [19:0]        INTEG_LIMIT_RST = 20'd100000;

  // Full-scale error when the beacon is lost.
  localparam logic signed [7:0] ERR_FULL = 8'sd100;

  // Shared multiplier: 17-bit signed by 22-bit signed.
  localparam int MUL_A_BITS = 17;
  localparam int MUL_B_BITS = 22;
  localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;

  localparam logic [2:0] MUL_DIFF = 3'd0;  // 100 * (right - left)
  localparam logic [2:0] MUL_STEP = 3'd1;  // error * time step
  localparam logic [2:0] MUL_P    = 3'd2;  // prop gain * error
  localparam logic [2:0] MUL_I    = 3'd3;  // integ gain * integral
  localparam logic [2:0] MUL_D    = 3'd4;  // deriv gain * error change

  // Shared restoring divider.
  localparam int DIV_BITS     = 24;
  localparam int DIV_CNT_BITS = $clog2(DIV_BITS);

  localparam logic DIV_ERR = 1'b0;  // |100*(r-l)| / (r+l)
  localparam logic DIV_D   = 1'b1;  // |deriv product| / (256*step)

  // Integral register width: holds +-(2^20-1).
  localparam int INTEG_BITS = 21;
  localparam int ACC_BITS   = 26;

  localparam int SAT_IN_BITS = 31;

  typedef struct packed {
    logic signed [15:0]      prop_gain;
    logic signed [15:0]      integ_gain;
    logic signed [15:0]      deriv_gain;
    logic [READING_BITS-1:0] front_min_level;
    logic [READING_BITS-1:0] rear_min_level;
    logic [19:0]             integral_limit;
  } cfg_t;

  typedef struct packed {
    logic       load_in;
    logic       mul_en;
    logic [2:0] mul_sel;
    logic       div_start;
    logic       div_sel;
    logic       err_special;
    logic       err_from_div;
    logic       integ_upd;
    logic       p_load;
    logic       i_load;
    logic       d_load;
    logic       d_zero;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic special;
    logic step_zero;
    logic div_done;
    logic out_free;
  } sts_t;

  // Saturate to int16.
  function automatic logic signed [15:0] sat16(input logic signed [SAT_IN_BITS-1:0] v);
    logic signed [15:0] r;
    if (v > 31'sd32767) r = 16'sh7FFF;
    else if (v < -31'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  // Divide by 256, truncating toward zero.
  function automatic logic signed [SAT_IN_BITS-1:0] trunc_q8(
    input logic signed [PROD_BITS-1:0] x
  );
    logic signed [PROD_BITS-1:0] t;
    t = x + (x[PROD_BITS-1] ? 39'sd255 : 39'sd0);
    return t[PROD_BITS-1:8];
  endfunction

endpackage

`default_nettype wire

/* src/bps_divider.sv */
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none

module bps_divider (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [bps_pkg::DIV_BITS-1:0]  dividend,
  input  wire logic [bps_pkg::DIV_BITS-1:0]  divisor,
  output logic                               done,
  output logic [bps_pkg::DIV_BITS-1:0]       quotient
);

  localparam logic [bps_pkg::DIV_CNT_BITS-1:0] LAST_CNT =
    bps_pkg::DIV_CNT_BITS'(bps_pkg::DIV_BITS - 1);

  logic                               busy;
  logic [bps_pkg::DIV_CNT_BITS-1:0]   cnt;
  logic [bps_pkg::DIV_BITS-1:0]       rem;
  logic [bps_pkg::DIV_BITS-1:0]       quo;
  logic [bps_pkg::DIV_BITS-1:0]       dvsr;
  logic [bps_pkg::DIV_BITS:0]         trial;
  logic [bps_pkg::DIV_BITS:0]         diff;
  logic                               fits;

  always_comb begin
    trial = {rem, quo[bps_pkg::DIV_BITS-1]};
    diff  = trial - {1'b0, dvsr};
    fits  = trial >= {1'b0, dvsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_CNT) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= dividend;
      dvsr <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[bps_pkg::DIV_BITS-1:0] : trial[bps_pkg::DIV_BITS-1:0];
      quo <= {quo[bps_pkg::DIV_BITS-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

/* src/bps_datapath.sv */
// Datapath: input capture, shared multiplier, divider, PID terms and output register.
`default_nettype none

module bps_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire bps_pkg::cfg_t                     cfg,
  input  wire bps_pkg::cmd_t                     cmd,
  output bps_pkg::sts_t                          sts,
  input  wire logic                              mode,
  input  wire logic [15:0]                       time_step,
  input  wire logic [bps_pkg::READING_BITS-1:0]  left_level,
  input  wire logic [bps_pkg::READING_BITS-1:0]  right_level,
  input  wire logic signed [15:0]                base_speed,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [15:0]                     left_speed,
  output logic signed [15:0]                     right_speed,
  output logic signed [7:0]                      error_pct
);

  localparam int RB = bps_pkg::READING_BITS;
  localparam int PB = bps_pkg::PROD_BITS;
  localparam int DB = bps_pkg::DIV_BITS;
  localparam int IB = bps_pkg::INTEG_BITS;
  localparam int AB = bps_pkg::ACC_BITS;

  // Captured transaction.
  logic                     mode_q;
  logic [15:0]              step_q;
  logic [RB-1:0]            left_q;
  logic [RB-1:0]            right_q;
  logic signed [15:0]       base_q;

  // Loop state.
  logic signed [7:0]        err;
  logic signed [7:0]        prev_error;
  logic signed [IB-1:0]     integral;

  logic signed [bps_pkg::MUL_A_BITS-1:0] mul_a;
  logic signed [bps_pkg::MUL_B_BITS-1:0] mul_b;
  logic signed [PB-1:0]     prod;

  logic signed [15:0]       p_term;
  logic signed [15:0]       i_term;
  logic signed [15:0]       d_term;

  logic [RB-1:0]            thresh;
  logic                     lost;
  logic [RB:0]              level_sum;
  logic signed [RB:0]       level_diff;
  logic signed [8:0]        err_delta;
  logic signed [7:0]        err_special;

  logic [PB-1:0]            prod_abs;
  logic [DB-1:0]            div_dividend;
  logic [DB-1:0]            div_divisor;
  logic                     div_done;
  logic [DB-1:0]            div_quo;
  logic                     div_neg;
  logic signed [DB:0]       d_signed;

  logic signed [AB-1:0]     acc;
  logic signed [AB-1:0]     lim;
  logic signed [AB-1:0]     acc_clamped;

  logic signed [17:0]       adj;
  logic signed [18:0]       speed_plus;
  logic signed [18:0]       speed_minus;
  logic signed [15:0]       sat_plus;
  logic signed [15:0]       sat_minus;

  // Lost-signal and degenerate-sum detection.
  always_comb begin
    thresh      = mode_q ? cfg.front_min_level : cfg.rear_min_level;
    lost        = (left_q < thresh) && (right_q < thresh);
    level_sum   = {1'b0, left_q} + {1'b0, right_q};
    level_diff  = $signed({1'b0, right_q}) - $signed({1'b0, left_q});
    err_delta   = {err[7], err} - {prev_error[7], prev_error};
    if (lost) begin
      err_special = (!prev_error[7] && (prev_error != 8'sd0)) ? bps_pkg::ERR_FULL
                                                              : -bps_pkg::ERR_FULL;
    end else begin
      err_special = 8'sd0;
    end
  end

  assign sts.special   = lost || (level_sum == '0);
  assign sts.step_zero = (step_q == 16'd0);
  assign sts.div_done  = div_done;
  assign sts.out_free  = !out_valid || out_ready;

  // Multiplier operand select.
  always_comb begin
    case (cmd.mul_sel)
      bps_pkg::MUL_DIFF: begin
        mul_a = 17'sd100;
        mul_b = {{(bps_pkg::MUL_B_BITS - RB - 1){level_diff[RB]}}, level_diff};
      end
      bps_pkg::MUL_STEP: begin
        mul_a = {1'b0, step_q};
        mul_b = {{(bps_pkg::MUL_B_BITS - 8){err[7]}}, err};
      end
      bps_pkg::MUL_P: begin
        mul_a = {cfg.prop_gain[15], cfg.prop_gain};
        mul_b = {{(bps_pkg::MUL_B_BITS - 8){err[7]}}, err};
      end
      bps_pkg::MUL_I: begin
        mul_a = {cfg.integ_gain[15], cfg.integ_gain};
        mul_b = {{(bps_pkg::MUL_B_BITS - IB){integral[IB-1]}}, integral};
      end
      bps_pkg::MUL_D: begin
        mul_a = {cfg.deriv_gain[15], cfg.deriv_gain};
        mul_b = {{(bps_pkg::MUL_B_BITS - 9){err_delta[8]}}, err_delta};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod <= mul_a * mul_b;
  end

  // Divider operands: magnitude of the product over the selected divisor.
  always_comb begin
    prod_abs     = prod[PB-1] ? -prod : prod;
    div_dividend = prod_abs[DB-1:0];
    div_divisor  = (cmd.div_sel == bps_pkg::DIV_ERR) ? {{(DB - RB - 1){1'b0}}, level_sum}
                                                     : {step_q, 8'd0};
    d_signed     = div_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) div_neg <= prod[PB-1];
  end

  bps_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Integral accumulate and clamp.
  always_comb begin
    acc = {{(AB - IB){integral[IB-1]}}, integral} + prod[AB-1:0];
    lim = {{(AB - 20){1'b0}}, cfg.integral_limit};
    if (acc > lim) acc_clamped = lim;
    else if (acc < -lim) acc_clamped = -lim;
    else acc_clamped = acc;
  end

  // Adjustment and motor speeds.
  always_comb begin
    adj = {{2{p_term[15]}}, p_term} + {{2{i_term[15]}}, i_term}
        + {{2{d_term[15]}}, d_term};
    speed_plus  = {{3{base_q[15]}}, base_q} + {adj[17], adj};
    speed_minus = {{3{base_q[15]}}, base_q} - {adj[17], adj};
    sat_plus    = bps_pkg::sat16({{12{speed_plus[18]}}, speed_plus});
    sat_minus   = bps_pkg::sat16({{12{speed_minus[18]}}, speed_minus});
  end

  // Transaction capture and term registers.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_q  <= mode;
      step_q  <= time_step;
      left_q  <= left_level;
      right_q <= right_level;
      base_q  <= base_speed;
    end
    if (cmd.err_special) err <= err_special;
    else if (cmd.err_from_div) err <= div_neg ? -div_quo[7:0] : div_quo[7:0];
    if (cmd.p_load) p_term <= bps_pkg::sat16(bps_pkg::trunc_q8(prod));
    if (cmd.i_load) i_term <= bps_pkg::sat16(bps_pkg::trunc_q8(prod));
    if (cmd.d_zero) d_term <= 16'sd0;
    else if (cmd.d_load) d_term <= bps_pkg::sat16({{(30 - DB){d_signed[DB]}}, d_signed});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral   <= '0;
      prev_error <= '0;
    end else begin
      if (cmd.integ_upd) integral <= acc_clamped[IB-1:0];
      if (cmd.out_load) prev_error <= err;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      left_speed  <= mode_q ? sat_plus : sat_minus;
      right_speed <= mode_q ? sat_minus : sat_plus;
      error_pct   <= err;
    end
  end

endmodule

`default_nettype wire

/* src/bps_controller.sv */
// Sequencer: steps one transaction through the shared multiplier and divider.
`default_nettype none

module bps_controller (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire bps_pkg::sts_t  sts,
  output bps_pkg::cmd_t       cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIFF  = 4'd1;
  localparam logic [3:0] S_EDIV  = 4'd2;
  localparam logic [3:0] S_EWAIT = 4'd3;
  localparam logic [3:0] S_ISTEP = 4'd4;
  localparam logic [3:0] S_IACC  = 4'd5;
  localparam logic [3:0] S_PTERM = 4'd6;
  localparam logic [3:0] S_ITERM = 4'd7;
  localparam logic [3:0] S_DDIV  = 4'd8;
  localparam logic [3:0] S_DWAIT = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  always_comb begin
    cmd        = '0;
    cmd.mul_sel = bps_pkg::MUL_DIFF;
    cmd.div_sel = bps_pkg::DIV_ERR;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
        if (in_valid) state_next = S_DIFF;
      end
      S_DIFF: begin
        if (sts.special) begin
          cmd.err_special = 1'b1;
          state_next      = S_ISTEP;
        end else begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = bps_pkg::MUL_DIFF;
          state_next  = S_EDIV;
        end
      end
      S_EDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = bps_pkg::DIV_ERR;
        state_next    = S_EWAIT;
      end
      S_EWAIT: begin
        cmd.div_sel = bps_pkg::DIV_ERR;
        if (sts.div_done) begin
          cmd.err_from_div = 1'b1;
          state_next       = S_ISTEP;
        end
      end
      S_ISTEP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = bps_pkg::MUL_STEP;
        state_next  = S_IACC;
      end
      S_IACC: begin
        cmd.integ_upd = 1'b1;
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = bps_pkg::MUL_P;
        state_next    = S_PTERM;
      end
      S_PTERM: begin
        cmd.p_load  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = bps_pkg::MUL_I;
        state_next  = S_ITERM;
      end
      S_ITERM: begin
        cmd.i_load  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = bps_pkg::MUL_D;
        if (sts.step_zero) begin
          cmd.d_zero = 1'b1;
          state_next = S_OUT;
        end else begin
          state_next = S_DDIV;
        end
      end
      S_DDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = bps_pkg::DIV_D;
        state_next    = S_DWAIT;
      end
      S_DWAIT: begin
        cmd.div_sel = bps_pkg::DIV_D;
        if (sts.div_done) begin
          cmd.d_load = 1'b1;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

`default_nettype wire

/* src/beacon_pid_steering_core.sv */
// Top level: PID steering from a beacon sensor pair, configuration registers.
// Skipping the error division (lost signal or zero reading sum) or the D division
//   (zero time step) shortens the path from input acceptance to out_valid.
// Transactions are taken one at a time, only in idle, as they share the single
//   17x22 multiplier and the restoring divider, used up to twice per transaction.
// Reset (rst, synchronous, active high): registers take their documented reset values,
//   integral and previous error clear, the output register empties.
`default_nettype none

module beacon_pid_steering_core (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // Configuration write port.
  input  wire logic                                  cfg_wr_en,
  input  wire logic [bps_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  wire logic [bps_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,
  // Input channel.
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic                                  mode,
  input  wire logic [15:0]                           time_step,
  input  wire logic [bps_pkg::READING_BITS-1:0]      left_level,
  input  wire logic [bps_pkg::READING_BITS-1:0]      right_level,
  input  wire logic signed [15:0]                    base_speed,
  // Output channel.
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed [15:0]                         left_speed,
  output logic signed [15:0]                         right_speed,
  output logic signed [7:0]                          error_pct
);

  bps_pkg::cfg_t cfg;
  bps_pkg::cmd_t cmd;
  bps_pkg::sts_t sts;

  // Configuration registers. The user must make writes only while the core is idle;
  // not enforced by the block; datapath reads them unshadowed. Unknown indexes dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain       <= bps_pkg::PROP_GAIN_RST;
      cfg.integ_gain      <= 16'sd0;
      cfg.deriv_gain      <= 16'sd0;
      cfg.front_min_level <= bps_pkg::MIN_LEVEL_RST;
      cfg.rear_min_level  <= bps_pkg::MIN_LEVEL_RST;
      cfg.integral_limit  <= bps_pkg::INTEG_LIMIT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        bps_pkg::REG_PROP_GAIN:   cfg.prop_gain       <= cfg_wdata[15:0];
        bps_pkg::REG_INTEG_GAIN:  cfg.integ_gain      <= cfg_wdata[15:0];
        bps_pkg::REG_DERIV_GAIN:  cfg.deriv_gain      <= cfg_wdata[15:0];
        bps_pkg::REG_FRONT_MIN:   cfg.front_min_level <= cfg_wdata[bps_pkg::READING_BITS-1:0];
        bps_pkg::REG_REAR_MIN:    cfg.rear_min_level  <= cfg_wdata[bps_pkg::READING_BITS-1:0];
        bps_pkg::REG_INTEG_LIMIT: cfg.integral_limit  <= cfg_wdata[19:0];
        default: ;
      endcase
    end
  end

  // Sequencer: accepts a transaction in idle, then walks error, integral,
  // P, I and D terms; waits in the last state until the output register frees.
  bps_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: holds the captured transaction, loop state, shared arithmetic and
  // the output register, so the next transaction may start while a result waits.
  bps_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .sts         (sts),
    .mode        (mode),
    .time_step   (time_step),
    .left_level  (left_level),
    .right_level (right_level),
    .base_speed  (base_speed),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .left_speed  (left_speed),
    .right_speed (right_speed),
    .error_pct   (error_pct)
  );

endmodule

`default_nettype wire

/* src/bps_checker.sv */
// Port-level checker for the steering core and its bind.
`default_nettype none

module bps_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [15:0] left_speed,
  input wire logic signed [15:0] right_speed,
  input wire logic signed [7:0]  error_pct
);

  // Output register empties on reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(left_speed)
      && $stable(right_speed) && $stable(error_pct))
    else $error("stalled result changed");

  // One transaction at a time: busy right after acceptance.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction accepted back to back");

  // Normalized error stays within full scale.
  a_err_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (error_pct <= 8'sd100) && (error_pct >= -8'sd100))
    else $error("error_pct out of range");

endmodule

bind beacon_pid_steering_core bps_checker u_bps_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .left_speed  (left_speed),
  .right_speed (right_speed),
  .error_pct   (error_pct)
);

`default_nettype wire
